// ===== hw/rtl/axhp_pkg.sv =====
`default_nettype none

package axhp_pkg;

    // default widths
    localparam int POS_BITS_DEF = 24;
    localparam int RPM_BITS_DEF = 16;

    // register file
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // register reset values
    localparam int TRAVEL_LIMIT_RST = 10000;
    localparam int BASE_RPM_RST     = 100;
    localparam int TOP_RPM_RST      = 200;

    typedef enum logic [1:0] {
        REG_TRAVEL_LIMIT = 2'd0,
        REG_INVERT_DIR   = 2'd1,
        REG_BASE_RPM     = 2'd2,
        REG_TOP_RPM      = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_HOME     = 2'd1,
        CMD_MOVE_ABS = 2'd2,
        CMD_MOVE_REL = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FAST    = 3'd1,
        PH_BACKOFF = 3'd2,
        PH_SLOW    = 3'd3,
        PH_ZERO    = 3'd4,
        PH_MEASURE = 3'd5,
        PH_RETURN  = 3'd6,
        PH_DONE    = 3'd7
    } t_phase;

    // speed as a percent of the mean of base and top rpm
    typedef enum logic [1:0] {
        PCT_20 = 2'd0,
        PCT_50 = 2'd1,
        PCT_60 = 2'd2,
        PCT_70 = 2'd3
    } t_pct;

    // narrow axis control state
    typedef struct packed {
        t_phase phase;
        logic   move_active;
        logic   heading_up;
        logic   enabled;
    } t_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/axhp_cfg.sv =====
`default_nettype none

module axhp_cfg
    import axhp_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int RPM_BITS = RPM_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output logic      [POS_BITS-1:0]  o_travel_limit,
    output logic                      o_invert_direction,
    output logic      [RPM_BITS-1:0]  o_base_rpm,
    output logic      [RPM_BITS-1:0]  o_top_rpm
);

    logic [POS_BITS-1:0] r_travel_limit;
    logic                r_invert_direction;
    logic [RPM_BITS-1:0] r_base_rpm;
    logic [RPM_BITS-1:0] r_top_rpm;
    logic                wr_en;
    t_reg                reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = t_reg'(paddr[3:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel_limit     <= POS_BITS'(TRAVEL_LIMIT_RST);
            r_invert_direction <= 1'b0;
            r_base_rpm         <= RPM_BITS'(BASE_RPM_RST);
            r_top_rpm          <= RPM_BITS'(TOP_RPM_RST);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_TRAVEL_LIMIT: r_travel_limit     <= pwdata[POS_BITS-1:0];
                REG_INVERT_DIR:   r_invert_direction <= pwdata[0];
                REG_BASE_RPM:     r_base_rpm         <= pwdata[RPM_BITS-1:0];
                REG_TOP_RPM:      r_top_rpm          <= pwdata[RPM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_sel)
            REG_TRAVEL_LIMIT: prdata = DATA_BITS'(r_travel_limit);
            REG_INVERT_DIR:   prdata = DATA_BITS'(r_invert_direction);
            REG_BASE_RPM:     prdata = DATA_BITS'(r_base_rpm);
            REG_TOP_RPM:      prdata = DATA_BITS'(r_top_rpm);
            default:          prdata = '0;
        endcase
    end

    assign o_travel_limit     = r_travel_limit;
    assign o_invert_direction = r_invert_direction;
    assign o_base_rpm         = r_base_rpm;
    assign o_top_rpm          = r_top_rpm;

endmodule

`default_nettype wire

// ===== hw/rtl/axhp_speed.sv =====
`default_nettype none

module axhp_speed
    import axhp_pkg::*;
#(
    parameter int RPM_BITS = RPM_BITS_DEF
) (
    input  wire logic [RPM_BITS-1:0] i_base_rpm,
    input  wire logic [RPM_BITS-1:0] i_top_rpm,
    input  wire t_pct                i_pct,
    output logic      [RPM_BITS-1:0] o_speed
);

    // scaled operand width: 3*mean and 7*mean/2 both stay below 4*2^RPM_BITS
    localparam int XW = RPM_BITS + 2;
    localparam logic [XW-1:0] RECIP5 = XW'((64'd1 << XW) / 64'd5);
    localparam logic [XW-1:0] FIVE   = XW'(5);

    logic [RPM_BITS:0]   sum;
    logic [RPM_BITS-1:0] mean;
    logic [RPM_BITS+2:0] mean_x7;
    logic [XW-1:0]       x;
    logic [2*XW-1:0]     prod;
    logic [XW-1:0]       q_est;
    logic [XW-1:0]       q_x5;
    logic [XW-1:0]       rem;
    logic [XW-1:0]       q;

    // mean of the two rpm settings
    assign sum     = {1'b0, i_base_rpm} + {1'b0, i_top_rpm};
    assign mean    = sum[RPM_BITS:1];
    assign mean_x7 = {mean, 3'b000} - (RPM_BITS+3)'(mean);

    // 20% = m/5, 60% = 3m/5, 70% = floor(7m/2)/5
    always_comb begin
        case (i_pct)
            PCT_60:  x = {1'b0, mean, 1'b0} + XW'(mean);
            PCT_70:  x = mean_x7[RPM_BITS+2:1];
            default: x = XW'(mean);
        endcase
    end

    // divide by five: reciprocal estimate is exact or one low
    assign prod  = (2*XW)'(x) * (2*XW)'(RECIP5);
    assign q_est = prod[2*XW-1:XW];
    assign q_x5  = {q_est[XW-3:0], 2'b00} + q_est;
    assign rem   = x - q_x5;
    assign q     = (rem >= FIVE) ? q_est + XW'(1) : q_est;

    // 50% is a plain halving
    always_comb begin
        case (i_pct)
            PCT_50:  o_speed = {1'b0, mean[RPM_BITS-1:1]};
            default: o_speed = q[RPM_BITS-1:0];
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/axhp_next.sv =====
`default_nettype none

module axhp_next
    import axhp_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int RPM_BITS = RPM_BITS_DEF
) (
    // transaction
    input  wire t_cmd                       i_cmd,
    input  wire logic                       i_home_switch,
    input  wire logic signed [POS_BITS:0]   i_target_position,
    input  wire logic signed [POS_BITS:0]   i_move_delta,
    // configuration
    input  wire logic        [POS_BITS-1:0] i_travel_limit,
    input  wire logic        [RPM_BITS-1:0] i_base_rpm,
    input  wire logic        [RPM_BITS-1:0] i_top_rpm,
    // current state
    input  wire t_ctl                       i_ctl,
    input  wire logic signed [POS_BITS:0]   i_position,
    input  wire logic        [POS_BITS-1:0] i_travel,
    input  wire logic        [POS_BITS-1:0] i_goal,
    input  wire logic        [RPM_BITS-1:0] i_speed,
    // next state
    output t_ctl                            o_ctl,
    output logic signed      [POS_BITS:0]   o_position,
    output logic             [POS_BITS-1:0] o_travel,
    output logic             [POS_BITS-1:0] o_goal,
    output logic             [RPM_BITS-1:0] o_speed,
    output logic                            o_step
);

    localparam logic signed [POS_BITS+1:0] ZERO_EXT = '0;

    logic signed [POS_BITS+1:0] cur_ext;
    logic signed [POS_BITS+1:0] trav_ext;
    logic signed [POS_BITS+1:0] limit_ext;
    logic signed [POS_BITS+1:0] goal_ext;
    logic signed [POS_BITS+1:0] tgt_raw;
    logic signed [POS_BITS+1:0] tgt_clamp;
    logic signed [POS_BITS:0]   step_pos;
    logic                       spd_load;
    t_pct                       spd_pct;
    logic        [RPM_BITS-1:0] spd_val;

    axhp_speed #(
        .RPM_BITS (RPM_BITS)
    ) u_speed (
        .i_base_rpm (i_base_rpm),
        .i_top_rpm  (i_top_rpm),
        .i_pct      (spd_pct),
        .o_speed    (spd_val)
    );

    // sign and zero extension for the compares
    assign cur_ext   = {i_position[POS_BITS], i_position};
    assign trav_ext  = {2'b00, i_travel};
    assign limit_ext = {2'b00, i_travel_limit};
    assign goal_ext  = {2'b00, i_goal};

    // one step in the current heading, wrapping
    assign step_pos = i_ctl.heading_up ? i_position + 1'b1 : i_position - 1'b1;

    // move target, clamped to [0, travel]
    always_comb begin
        if (i_cmd == CMD_MOVE_ABS) begin
            tgt_raw = {i_target_position[POS_BITS], i_target_position};
        end else begin
            tgt_raw = cur_ext + {i_move_delta[POS_BITS], i_move_delta};
        end
        if (tgt_raw < ZERO_EXT) begin
            tgt_clamp = ZERO_EXT;
        end else if (tgt_raw > trav_ext) begin
            tgt_clamp = trav_ext;
        end else begin
            tgt_clamp = tgt_raw;
        end
    end

    // command decode and homing sequence
    always_comb begin
        o_ctl      = i_ctl;
        o_position = i_position;
        o_travel   = i_travel;
        o_goal     = i_goal;
        o_step     = 1'b0;
        spd_load   = 1'b0;
        spd_pct    = PCT_50;

        unique case (i_cmd)
            CMD_TICK: begin
                unique case (i_ctl.phase)
                    PH_FAST: begin
                        if (!i_home_switch) begin
                            o_step = 1'b1;
                        end else begin
                            o_ctl.phase      = PH_BACKOFF;
                            o_ctl.heading_up = 1'b1;
                            spd_load         = 1'b1;
                            spd_pct          = PCT_20;
                        end
                    end
                    PH_BACKOFF: begin
                        if (i_home_switch) begin
                            o_step = 1'b1;
                        end else begin
                            o_ctl.phase      = PH_SLOW;
                            o_ctl.heading_up = 1'b0;
                            spd_load         = 1'b1;
                            spd_pct          = PCT_20;
                        end
                    end
                    PH_SLOW: begin
                        if (!i_home_switch) begin
                            o_step = 1'b1;
                        end else begin
                            o_position       = '0;
                            o_ctl.phase      = PH_ZERO;
                            o_ctl.heading_up = 1'b1;
                            spd_load         = 1'b1;
                            spd_pct          = PCT_60;
                        end
                    end
                    PH_ZERO: begin
                        o_position  = '0;
                        o_ctl.phase = PH_MEASURE;
                        spd_load    = 1'b1;
                        spd_pct     = PCT_70;
                    end
                    PH_MEASURE: begin
                        if (cur_ext < limit_ext) begin
                            o_step = 1'b1;
                        end else begin
                            o_travel         = i_position[POS_BITS-1:0];
                            o_ctl.phase      = PH_RETURN;
                            o_ctl.heading_up = 1'b0;
                        end
                    end
                    PH_RETURN: begin
                        if (cur_ext > ZERO_EXT) begin
                            o_step = 1'b1;
                        end else begin
                            o_ctl.phase   = PH_DONE;
                            o_ctl.enabled = 1'b0;
                        end
                    end
                    PH_DONE: begin
                        // positioning: one step per tick until the goal
                        if (i_ctl.move_active) begin
                            if (cur_ext == goal_ext) begin
                                o_ctl.move_active = 1'b0;
                                o_ctl.enabled     = 1'b0;
                            end else begin
                                o_ctl.enabled = 1'b1;
                                o_step        = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_HOME: begin
                o_ctl.phase      = PH_FAST;
                o_ctl.enabled    = 1'b1;
                o_ctl.heading_up = 1'b0;
                spd_load         = 1'b1;
                spd_pct          = PCT_50;
            end
            CMD_MOVE_ABS, CMD_MOVE_REL: begin
                // a move to the current position leaves everything as is
                if (tgt_clamp != cur_ext) begin
                    o_ctl.heading_up  = tgt_clamp > cur_ext;
                    o_ctl.move_active = 1'b1;
                    o_goal            = tgt_clamp[POS_BITS-1:0];
                end
            end
            default: ;
        endcase

        if (o_step) begin
            o_position = step_pos;
        end
    end

    assign o_speed = spd_load ? spd_val : i_speed;

endmodule

`default_nettype wire

// ===== hw/rtl/axis_homing_and_positioning_core.sv =====
// Stepper axis homing sequencer and point-to-point positioner.
// Input channel (i_in_valid / o_in_stall) carries one command per transaction:
// a tick with the home switch level, start homing, absolute move or relative
// move. Output channel (o_out_valid / i_out_stall) returns exactly one result
// per transaction: step pulse, direction pin, enable, speed, homed, moving,
// position, measured travel and homing phase, all as they stand after it.
// Timing: an input register and a result register surround the combinational
// state update; the result register takes each result from the input register,
// and one transaction per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result register holds its value, the input
// register still takes one more transaction, and o_in_stall then rises
// until the result is taken.
// The APB port holds travel_limit, invert_direction, base_rpm and top_rpm at
// byte addresses 0, 4, 8 and 12; pready is always high. Write them only
// while the axis has no transaction in flight.
// Reset is synchronous: registers return to their defaults, the phase goes to
// idle, position, travel, goal and speed go to zero, no result is pending.
`default_nettype none

module axis_homing_and_positioning_core
    import axhp_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int RPM_BITS = RPM_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic        [ADDR_BITS-1:0] paddr,
    input  wire logic        [DATA_BITS-1:0] pwdata,
    output logic             [DATA_BITS-1:0] prdata,
    output logic                            pready,
    // command channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic        [1:0]          i_cmd,
    input  wire logic                       i_home_switch,
    input  wire logic signed [POS_BITS:0]   i_target_position,
    input  wire logic signed [POS_BITS:0]   i_move_delta,
    // result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_step_pulse,
    output logic                            o_dir_pin,
    output logic                            o_drive_enable,
    output logic             [RPM_BITS-1:0] o_speed_setting,
    output logic                            o_homed,
    output logic                            o_moving,
    output logic signed      [POS_BITS:0]   o_step_position,
    output logic             [POS_BITS-1:0] o_measured_travel,
    output logic             [2:0]          o_homing_phase
);

    // configuration registers
    logic [POS_BITS-1:0] travel_limit;
    logic                invert_direction;
    logic [RPM_BITS-1:0] base_rpm;
    logic [RPM_BITS-1:0] top_rpm;

    // input register
    logic                     r_in_valid;
    t_cmd                     r_in_cmd;
    logic                     r_in_sw;
    logic signed [POS_BITS:0] r_in_target;
    logic signed [POS_BITS:0] r_in_delta;

    // axis state
    t_ctl                     r_ctl;
    logic signed [POS_BITS:0] r_position;
    logic [POS_BITS-1:0]      r_travel;
    logic [POS_BITS-1:0]      r_goal;
    logic [RPM_BITS-1:0]      r_speed;

    t_ctl                     n_ctl;
    logic signed [POS_BITS:0] n_position;
    logic [POS_BITS-1:0]      n_travel;
    logic [POS_BITS-1:0]      n_goal;
    logic [RPM_BITS-1:0]      n_speed;
    logic                     n_step;

    // result register
    logic                     r_out_valid;
    logic                     r_out_step;
    logic                     r_out_dir;
    logic                     r_out_enable;
    logic [RPM_BITS-1:0]      r_out_speed;
    logic                     r_out_homed;
    logic                     r_out_moving;
    logic signed [POS_BITS:0] r_out_position;
    logic [POS_BITS-1:0]      r_out_travel;
    t_phase                   r_out_phase;

    logic in_accept;
    logic advance;

    axhp_cfg #(
        .POS_BITS (POS_BITS),
        .RPM_BITS (RPM_BITS)
    ) u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_travel_limit     (travel_limit),
        .o_invert_direction (invert_direction),
        .o_base_rpm         (base_rpm),
        .o_top_rpm          (top_rpm)
    );

    axhp_next #(
        .POS_BITS (POS_BITS),
        .RPM_BITS (RPM_BITS)
    ) u_next (
        .i_cmd             (r_in_cmd),
        .i_home_switch     (r_in_sw),
        .i_target_position (r_in_target),
        .i_move_delta      (r_in_delta),
        .i_travel_limit    (travel_limit),
        .i_base_rpm        (base_rpm),
        .i_top_rpm         (top_rpm),
        .i_ctl             (r_ctl),
        .i_position        (r_position),
        .i_travel          (r_travel),
        .i_goal            (r_goal),
        .i_speed           (r_speed),
        .o_ctl             (n_ctl),
        .o_position        (n_position),
        .o_travel          (n_travel),
        .o_goal            (n_goal),
        .o_speed           (n_speed),
        .o_step            (n_step)
    );

    // handshake: the held transaction moves on when the result slot frees up
    assign advance    = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~advance;
    assign in_accept  = i_in_valid & ~o_in_stall;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd    <= t_cmd'(i_cmd);
            r_in_sw     <= i_home_switch;
            r_in_target <= i_target_position;
            r_in_delta  <= i_move_delta;
        end
    end

    // axis state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl      <= '{phase: PH_IDLE, move_active: 1'b0, heading_up: 1'b0,
                            enabled: 1'b0};
            r_position <= '0;
            r_travel   <= '0;
            r_goal     <= '0;
            r_speed    <= '0;
        end else if (advance) begin
            r_ctl      <= n_ctl;
            r_position <= n_position;
            r_travel   <= n_travel;
            r_goal     <= n_goal;
            r_speed    <= n_speed;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_step     <= n_step;
            r_out_dir      <= n_ctl.heading_up ^ invert_direction;
            r_out_enable   <= n_ctl.enabled;
            r_out_speed    <= n_speed;
            r_out_homed    <= (n_ctl.phase == PH_DONE);
            r_out_moving   <= n_ctl.move_active;
            r_out_position <= n_position;
            r_out_travel   <= n_travel;
            r_out_phase    <= n_ctl.phase;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_step_pulse      = r_out_step;
    assign o_dir_pin         = r_out_dir;
    assign o_drive_enable    = r_out_enable;
    assign o_speed_setting   = r_out_speed;
    assign o_homed           = r_out_homed;
    assign o_moving          = r_out_moving;
    assign o_step_position   = r_out_position;
    assign o_measured_travel = r_out_travel;
    assign o_homing_phase    = r_out_phase;

    // a step always moves the position
    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_step |=> r_position != $past(r_position))
        else $error("step issued without a position change");

    // axis state only changes when a transaction is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_position) && $stable(r_ctl) && $stable(r_goal))
        else $error("axis state changed without a transaction");

    // a transaction waiting in the input register is neither lost nor changed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_cmd)
            && $stable(r_in_target) && $stable(r_in_delta))
        else $error("held command transaction was lost or changed");

    // the driver is never enabled before homing has been started
    a_idle_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.phase == PH_IDLE |-> !r_ctl.enabled)
        else $error("driver enabled while idle");

endmodule

`default_nettype wire
